// ===== sv/fodk_pkg.sv =====
// ----------------------------------------------------------------------------
// fodk_pkg: shared types and constants for the X-drive kinematics block
// Item structs, configuration register codes, reset values and Q16 factors.
// ----------------------------------------------------------------------------
package fodk_pkg;

	// Configuration register codes
	typedef enum logic [1:0] {
		CFG_CENTER_DISTANCE = 2'd0,
		CFG_RPM_GAIN        = 2'd1,
		CFG_MAX_RPM         = 2'd2
	} cfg_index_t;

	localparam int CFG_DATA_W = 20;

	localparam logic [15:0] RST_CENTER_DISTANCE = 16'd19975;
	localparam logic [19:0] RST_RPM_GAIN        = 20'd611072;
	localparam logic [14:0] RST_MAX_RPM         = 15'd8000;

	// pi/2 in Q30, 1/sqrt2 and sqrt2 in Q16
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;
	localparam logic signed [17:0] SQRT2_Q16     = 18'sd92682;

	// Quarter turn of a 16-bit binary angle
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	// Queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic              command;
		logic signed [15:0] forward_speed;
		logic signed [15:0] sideways_speed;
		logic signed [15:0] turn_rate;
		logic [15:0]       robot_yaw;
		logic [15:0]       turret_angle;
	} cmd_item_t;

	typedef struct packed {
		logic signed [15:0] front_left_rpm;
		logic signed [15:0] front_right_rpm;
		logic signed [15:0] rear_right_rpm;
		logic signed [15:0] rear_left_rpm;
		logic [3:0]        clamp_flags;
	} wheel_item_t;

	// Classified command: translation, turn rate and heading sine/cosine in Q12
	typedef struct packed {
		logic signed [15:0] forward_speed;
		logic signed [15:0] sideways_speed;
		logic signed [15:0] turn_rate;
		logic signed [13:0] sin_q12;
		logic signed [13:0] cos_q12;
	} work_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [15:0] center_distance;
		logic [19:0] rpm_per_mps_gain;
		logic [14:0] max_wheel_rpm;
	} cfg_regs_t;

endpackage

// ===== sv/fodk_front.sv =====
// ----------------------------------------------------------------------------
// fodk_front: command intake and heading classification
// Picks the heading from the mode, looks up sine and cosine in a quarter-wave
// table and registers the classified item for the queue.
// ----------------------------------------------------------------------------
module fodk_front #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  fodk_pkg::cmd_item_t    cmd,
	output logic                   push,
	output fodk_pkg::work_item_t   work,
	input  fodk_pkg::queue_stat_t  qstat
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_W = 14 + IDX_W;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// Sine of a Q30 angle by a truncated series, rounded to Q12
	function automatic logic [12:0] sine_entry(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		return 13'((s + 64'h2_0000) >> 18);
	endfunction

	// Table index for an angle, mirrored in odd quadrants
	function automatic logic [IDX_W-1:0] tab_index(input logic [15:0] ang);
		logic [PROD_W-1:0] prod;
		logic [IDX_W-1:0]  i;
		prod = PROD_W'(ang[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
		i    = IDX_W'(prod >> 14);
		return ang[14] ? IDX_W'(SINE_TABLE_DEPTH) - i : i;
	endfunction

	logic [12:0] sine_tab [SINE_TABLE_DEPTH+1];

	// Build the quarter-wave table at elaboration
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
		localparam longint unsigned XK =
			(fodk_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
		assign sine_tab[k] = sine_entry(XK);
	end

	logic [15:0]        heading;
	logic [15:0]        cos_ang;
	logic [IDX_W-1:0]   sin_idx;
	logic [IDX_W-1:0]   cos_idx;
	logic signed [13:0] sin_mag;
	logic signed [13:0] cos_mag;
	logic signed [13:0] sin_val;
	logic signed [13:0] cos_val;
	logic               accept;

	fodk_pkg::work_item_t work_s1;
	logic                 work_valid_s1;

	// Pick heading and look up sine and cosine
	always_comb begin
		heading = cmd.command ? cmd.robot_yaw - cmd.turret_angle : cmd.robot_yaw;
		cos_ang = heading + fodk_pkg::QUARTER_TURN;
		sin_idx = tab_index(heading);
		cos_idx = tab_index(cos_ang);
		sin_mag = $signed({1'b0, sine_tab[sin_idx]});
		cos_mag = $signed({1'b0, sine_tab[cos_idx]});
		sin_val = heading[15] ? -sin_mag : sin_mag;
		cos_val = cos_ang[15] ? -cos_mag : cos_mag;
	end

	// Hold the intake while the registered item cannot enter the queue
	assign cmd_stall = work_valid_s1 && qstat.full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = work_valid_s1 && !qstat.full;
	assign work      = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_s1 <= 1'b0;
		end else begin
			work_valid_s1 <= accept || cmd_stall;
		end
	end

	// Load the classified item
	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.forward_speed  <= cmd.forward_speed;
			work_s1.sideways_speed <= cmd.sideways_speed;
			work_s1.turn_rate      <= cmd.turn_rate;
			work_s1.sin_q12        <= sin_val;
			work_s1.cos_q12        <= cos_val;
		end
	end

endmodule

// ===== sv/fodk_queue.sv =====
// ----------------------------------------------------------------------------
// fodk_queue: short item queue between front and back
// Register-based FIFO with separate read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module fodk_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  fodk_pkg::work_item_t   push_data,
	input  logic                   pop,
	output fodk_pkg::work_item_t   pop_data,
	output fodk_pkg::queue_stat_t  qstat
);

	localparam int PTR_W = $clog2(fodk_pkg::QUEUE_DEPTH);

	fodk_pkg::work_item_t entry_q [fodk_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign qstat.full  = count_q == (PTR_W+1)'(fodk_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_data    = entry_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/fodk_back.sv =====
// ----------------------------------------------------------------------------
// fodk_back: rotation, X-drive mixing, rpm scaling and clamping
// Eight-stage pipeline plus output register, all stages moving together
// whenever the output register is free or being taken.
// ----------------------------------------------------------------------------
module fodk_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fodk_pkg::cfg_regs_t    cfg,
	output logic                   pop,
	input  fodk_pkg::work_item_t   pop_data,
	input  fodk_pkg::queue_stat_t  qstat,
	output logic                   wheel_valid,
	input  logic                   wheel_stall,
	output fodk_pkg::wheel_item_t  wheel
);

	localparam int STAGES = 8;
	localparam logic [54:0] HALF_Q24 = 55'd1 << 23;
	localparam logic [51:0] HALF_Q28 = 52'd1 << 27;

	logic               en;
	logic [STAGES-1:0]  vld_q;
	logic               out_valid_q;
	fodk_pkg::wheel_item_t wheel_q;

	// Stage 1: heading products and turn product
	logic signed [29:0] fcos_s1, ssin_s1, fsin_s1, scos_s1;
	logic signed [32:0] rc_s1;
	// Stage 2: rotated vector and rotation term in Q44
	logic signed [30:0] vx_s2, vy_s2;
	logic signed [50:0] rot_s2;
	// Stage 3: per-wheel translation sums
	logic signed [31:0] trans_s3 [4];
	logic signed [50:0] rot_s3;
	// Stage 4: scaled by 1/sqrt2
	logic signed [49:0] mix_s4 [4];
	logic signed [50:0] rot_s4;
	// Stage 5: wheel speed in Q44
	logic signed [54:0] w_s5 [4];
	// Stage 6: wheel speed in Q20
	logic signed [30:0] w20_s6 [4];
	// Stage 7: rpm in Q28
	logic signed [51:0] prod_s7 [4];
	// Stage 8: integer rpm
	logic signed [23:0] rpm_s8 [4];

	logic [54:0]        rnd24 [4];
	logic [51:0]        rnd28 [4];
	logic signed [23:0] lim;
	logic signed [23:0] nlim;
	logic signed [23:0] sat [4];
	logic [3:0]         flag;

	// Advance the whole pipe when the output register can take an item
	assign en          = !out_valid_q || !wheel_stall;
	assign pop         = en && !qstat.empty;
	assign wheel_valid = out_valid_q;
	assign wheel       = wheel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[STAGES-2:0], pop};
			out_valid_q <= vld_q[STAGES-1];
		end
	end

	// Round half away from zero, then clamp to the limit
	always_comb begin
		lim  = $signed({9'd0, cfg.max_wheel_rpm});
		nlim = -lim;
		for (int k = 0; k < 4; k++) begin
			rnd24[k] = w_s5[k] + HALF_Q24 - 55'(w_s5[k][54]);
			rnd28[k] = prod_s7[k] + HALF_Q28 - 52'(prod_s7[k][51]);
			if (rpm_s8[k] > lim) begin
				sat[k]  = lim;
				flag[k] = 1'b1;
			end else if (rpm_s8[k] < nlim) begin
				sat[k]  = nlim;
				flag[k] = 1'b1;
			end else begin
				sat[k]  = rpm_s8[k];
				flag[k] = 1'b0;
			end
		end
	end

	// Move payload down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			fcos_s1 <= pop_data.forward_speed * pop_data.cos_q12;
			ssin_s1 <= pop_data.sideways_speed * pop_data.sin_q12;
			fsin_s1 <= pop_data.forward_speed * pop_data.sin_q12;
			scos_s1 <= pop_data.sideways_speed * pop_data.cos_q12;
			rc_s1   <= pop_data.turn_rate * $signed({1'b0, cfg.center_distance});

			vx_s2  <= fcos_s1 + ssin_s1;
			vy_s2  <= scos_s1 - fsin_s1;
			rot_s2 <= rc_s1 * fodk_pkg::SQRT2_Q16;

			trans_s3[0] <= vx_s2 - vy_s2;
			trans_s3[1] <= -vx_s2 - vy_s2;
			trans_s3[2] <= vy_s2 - vx_s2;
			trans_s3[3] <= vx_s2 + vy_s2;
			rot_s3      <= rot_s2;

			rot_s4 <= rot_s3;
			for (int k = 0; k < 4; k++) begin
				mix_s4[k]  <= trans_s3[k] * fodk_pkg::INV_SQRT2_Q16;
				w_s5[k]    <= $signed({mix_s4[k][49], mix_s4[k], 4'd0})
					+ $signed({{4{rot_s4[50]}}, rot_s4});
				w20_s6[k]  <= $signed(rnd24[k][54:24]);
				prod_s7[k] <= w20_s6[k] * $signed({1'b0, cfg.rpm_per_mps_gain});
				rpm_s8[k]  <= $signed(rnd28[k][51:28]);
			end

			wheel_q.front_left_rpm  <= sat[0][15:0];
			wheel_q.front_right_rpm <= sat[1][15:0];
			wheel_q.rear_right_rpm  <= sat[2][15:0];
			wheel_q.rear_left_rpm   <= sat[3][15:0];
			wheel_q.clamp_flags     <= flag;
		end
	end

endmodule

// ===== sv/field_oriented_xdrive_kinematics.sv =====
// ----------------------------------------------------------------------------
// field_oriented_xdrive_kinematics: velocity command to four wheel rpm
// Path: the front register loads at the accepting edge, then the item passes
//   through 1 queue slot, 8 back stages and 1 output register to wheel valid.
// Throughput: one command per cycle while the receiver does not stall; the back pipeline sets the pace.
// Reset: asynchronous, clears queue and stage valids, loads register defaults.
// ----------------------------------------------------------------------------
module field_oriented_xdrive_kinematics #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  fodk_pkg::cmd_item_t    cmd,
	output logic                   wheel_valid,
	input  logic                   wheel_stall,
	output fodk_pkg::wheel_item_t  wheel,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  fodk_pkg::cfg_index_t   cfg_index,
	input  logic [fodk_pkg::CFG_DATA_W-1:0] cfg_data
);

	fodk_pkg::cfg_regs_t   cfg_q;
	fodk_pkg::work_item_t  work;
	fodk_pkg::work_item_t  pop_data;
	fodk_pkg::queue_stat_t qstat;
	logic                  push;
	logic                  pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_distance  <= fodk_pkg::RST_CENTER_DISTANCE;
			cfg_q.rpm_per_mps_gain <= fodk_pkg::RST_RPM_GAIN;
			cfg_q.max_wheel_rpm    <= fodk_pkg::RST_MAX_RPM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fodk_pkg::CFG_CENTER_DISTANCE: begin
					cfg_q.center_distance <= cfg_data[15:0];
				end
				fodk_pkg::CFG_RPM_GAIN: begin
					cfg_q.rpm_per_mps_gain <= cfg_data[19:0];
				end
				fodk_pkg::CFG_MAX_RPM: begin
					cfg_q.max_wheel_rpm <= cfg_data[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	fodk_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.work      (work),
		.qstat     (qstat)
	);

	fodk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (work),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	fodk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop         (pop),
		.pop_data    (pop_data),
		.qstat       (qstat),
		.wheel_valid (wheel_valid),
		.wheel_stall (wheel_stall),
		.wheel       (wheel)
	);

`ifndef SYNTHESIS
	// The front-left and rear-right wheel commands stay within the configured limit
	a_wheel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_valid |->
			(wheel.front_left_rpm  <= $signed({1'b0, cfg_q.max_wheel_rpm})) &&
			(wheel.front_left_rpm  >= -$signed({1'b0, cfg_q.max_wheel_rpm})) &&
			(wheel.rear_right_rpm  <= $signed({1'b0, cfg_q.max_wheel_rpm})) &&
			(wheel.rear_right_rpm  >= -$signed({1'b0, cfg_q.max_wheel_rpm})))
		else $error("wheel rpm outside clamp limit");

	// A flagged front-right wheel sits exactly at the limit
	a_flag_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_valid && wheel.clamp_flags[1] |->
			(wheel.front_right_rpm == $signed({1'b0, cfg_q.max_wheel_rpm})) ||
			(wheel.front_right_rpm == -$signed({1'b0, cfg_q.max_wheel_rpm})))
		else $error("clamp flag set on unclamped wheel");

	// Queue never reports full and empty together
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue status inconsistent");
`endif

endmodule

// ===== bench/field_oriented_xdrive_kinematics_tb.sv =====
// ----------------------------------------------------------------------------
// field_oriented_xdrive_kinematics_tb: self-checking bench for the X-drive block
// Drives velocity commands and register writes, predicts the four clamped
// wheel speeds of every command and compares each wheel item in order.
// ----------------------------------------------------------------------------
module field_oriented_xdrive_kinematics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SINE_DEPTH = 256;
	localparam int LATENCY = 11;
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 150;

	// Heading modes and the register index that decodes to nothing
	localparam logic MODE_FIELD = 1'b0;
	localparam logic MODE_TURRET = 1'b1;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	fodk_pkg::cmd_item_t cmd = '0;
	logic wheel_valid;
	logic wheel_stall = 1'b0;
	fodk_pkg::wheel_item_t wheel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	fodk_pkg::cfg_index_t cfg_index = fodk_pkg::CFG_CENTER_DISTANCE;
	logic [fodk_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies used by the predictor
	logic [15:0] cfg_center = fodk_pkg::RST_CENTER_DISTANCE;
	logic [19:0] cfg_gain = fodk_pkg::RST_RPM_GAIN;
	logic [14:0] cfg_max_rpm = fodk_pkg::RST_MAX_RPM;

	longint sine_q12_tab [0:SINE_DEPTH];
	fodk_pkg::wheel_item_t wheel_expect_q[$];

	bit send_gaps_en = 1'b1;
	bit recv_idle_en = 1'b1;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	int cmds_sent = 0;
	int wheels_checked = 0;
	int cfg_writes = 0;
	int mismatch_count = 0;

	field_oriented_xdrive_kinematics #(
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.wheel_valid(wheel_valid),
		.wheel_stall(wheel_stall),
		.wheel(wheel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Quarter-wave sine table, Q30 Taylor series rounded to Q12
	function automatic void build_sine_table();
		longint unsigned divs [0:5];
		longint unsigned x, x2, t, s;
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x = (fodk_pkg::HALF_PI_Q30 * longint'(k)) / longint'(SINE_DEPTH);
			x2 = (x * x) >> 30;
			t = 64'd1 << 30;
			for (int j = 0; j < 6; j++)
				t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[j];
			s = (x * t) >> 30;
			sine_q12_tab[k] = longint'((s + (64'd1 << 17)) >> 18);
		end
	endfunction

	// Sine of a binary angle by table lookup, no interpolation
	function automatic longint table_sine(logic [15:0] ang);
		int i;
		int idx;
		longint v;
		i = (int'(ang[13:0]) * SINE_DEPTH) / 16384;
		idx = ang[14] ? SINE_DEPTH - i : i;
		v = sine_q12_tab[idx];
		return ang[15] ? -v : v;
	endfunction

	// Shift right, rounding half away from zero
	function automatic longint round_shift(longint x, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		if (x >= 0)
			return (x + half) >>> sh;
		return -((-x + half) >>> sh);
	endfunction

	// Rotate by heading, mix into four wheels, scale to rpm and clamp
	function automatic fodk_pkg::wheel_item_t predict_wheels(fodk_pkg::cmd_item_t c);
		logic [15:0] heading;
		longint f, s, r, sn, cs, vx, vy, rot, w, rpm, lim;
		longint trans [0:3];
		logic [15:0] speed [0:3];
		fodk_pkg::wheel_item_t res;
		heading = c.robot_yaw;
		if (c.command == MODE_TURRET)
			heading = c.robot_yaw - c.turret_angle;
		sn = table_sine(heading);
		cs = table_sine(heading + fodk_pkg::QUARTER_TURN);
		f = longint'($signed(c.forward_speed));
		s = longint'($signed(c.sideways_speed));
		r = longint'($signed(c.turn_rate));
		vx = f * cs + s * sn;
		vy = s * cs - f * sn;
		rot = r * longint'(cfg_center) * longint'(fodk_pkg::SQRT2_Q16);
		trans = '{vx - vy, -vx - vy, -vx + vy, vx + vy};
		lim = longint'(cfg_max_rpm);
		res.clamp_flags = '0;
		for (int k = 0; k < 4; k++) begin
			w = trans[k] * longint'(fodk_pkg::INV_SQRT2_Q16) * 16 + rot;
			rpm = round_shift(round_shift(w, 24) * longint'(cfg_gain), 28);
			if (rpm > lim) begin
				rpm = lim;
				res.clamp_flags[k] = 1'b1;
			end else if (rpm < -lim) begin
				rpm = -lim;
				res.clamp_flags[k] = 1'b1;
			end
			speed[k] = rpm[15:0];
		end
		res.front_left_rpm = speed[0];
		res.front_right_rpm = speed[1];
		res.rear_right_rpm = speed[2];
		res.rear_left_rpm = speed[3];
		return res;
	endfunction

	// Receiver: random stalls, quiet stretches and counted hold-offs
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			wheel_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (!recv_idle_en) begin
			wheel_stall <= 1'b0;
		end else begin
			wheel_stall <= ($urandom_range(99) < 33);
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare every accepted wheel item with the oldest prediction
	always @(posedge clk) begin
		fodk_pkg::wheel_item_t want;
		if (arst_n && wheel_valid && !wheel_stall) begin
			if (wheel_expect_q.size() == 0) begin
				$display("%0t: unexpected wheel item, expected none, got fl %0d fr %0d",
					$time, $signed(wheel.front_left_rpm), $signed(wheel.front_right_rpm));
				mismatch_count++;
			end else begin
				want = wheel_expect_q.pop_front();
				check_field("front_left_rpm", $signed(want.front_left_rpm),
					$signed(wheel.front_left_rpm));
				check_field("front_right_rpm", $signed(want.front_right_rpm),
					$signed(wheel.front_right_rpm));
				check_field("rear_right_rpm", $signed(want.rear_right_rpm),
					$signed(wheel.rear_right_rpm));
				check_field("rear_left_rpm", $signed(want.rear_left_rpm),
					$signed(wheel.rear_left_rpm));
				check_field("clamp_flags", want.clamp_flags, wheel.clamp_flags);
				wheels_checked++;
			end
		end
	end

	// Offer one command, hold it until accepted, then record its prediction
	task automatic send_cmd(fodk_pkg::cmd_item_t c);
		@(negedge clk);
		if (send_gaps_en && $urandom_range(99) < 33) begin
			cmd_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 33);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		wheel_expect_q.push_back(predict_wheels(c));
		cmds_sent++;
	endtask

	task automatic send_fields(logic mode, logic [15:0] f, logic [15:0] s, logic [15:0] r,
		logic [15:0] yaw, logic [15:0] tur);
		fodk_pkg::cmd_item_t c;
		c.command = mode;
		c.forward_speed = f;
		c.sideways_speed = s;
		c.turn_rate = r;
		c.robot_yaw = yaw;
		c.turret_angle = tur;
		send_cmd(c);
	endtask

	// Drop valid and wait until every predicted wheel item has come out
	task automatic wait_for_wheels();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (wheel_expect_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_register(fodk_pkg::cfg_index_t idx,
		logic [fodk_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fodk_pkg::CFG_CENTER_DISTANCE: cfg_center = data[15:0];
			fodk_pkg::CFG_RPM_GAIN: cfg_gain = data;
			fodk_pkg::CFG_MAX_RPM: cfg_max_rpm = data[14:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_speed();
		case ($urandom_range(3))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(8192) - 4096);
			default: begin
				case ($urandom_range(2))
					0: return 16'h8000;
					1: return 16'h7FFF;
					default: return 16'h0000;
				endcase
			end
		endcase
	endfunction

	// Mostly uniform angles, some right at a quadrant edge
	function automatic logic [15:0] rand_angle();
		if ($urandom_range(3) != 0)
			return 16'($urandom);
		return 16'($urandom_range(3) * 16384 + $urandom_range(2) - 1);
	endfunction

	function automatic fodk_pkg::cmd_item_t rand_cmd();
		fodk_pkg::cmd_item_t c;
		c.command = 1'($urandom_range(1));
		c.forward_speed = rand_speed();
		c.sideways_speed = rand_speed();
		c.turn_rate = rand_speed();
		c.robot_yaw = rand_angle();
		c.turret_angle = rand_angle();
		return c;
	endfunction

	// Pick zero, full scale, the reset value or anything, with noise above
	function automatic logic [fodk_pkg::CFG_DATA_W-1:0] rand_reg(int width,
		logic [19:0] rst);
		logic [fodk_pkg::CFG_DATA_W-1:0] data;
		logic [19:0] full;
		full = 20'((64'd1 << width) - 1);
		data = 20'($urandom);
		case ($urandom_range(4))
			0: data = data & ~full;
			1: data = data | full;
			2: data = (data & ~full) | rst;
			default: ;
		endcase
		return data;
	endfunction

	task automatic test_directed();
		send_fields(MODE_FIELD, 0, 0, 0, 0, 0);
		send_fields(MODE_FIELD, 4096, 0, 0, 0, 0);
		send_fields(MODE_FIELD, 0, 4096, 0, 16384, 0);
		send_fields(MODE_FIELD, 32767, 32767, 32767, 0, 0);
		send_fields(MODE_FIELD, -32768, -32768, -32768, 32768, 0);
		send_fields(MODE_FIELD, 1000, -2000, 500, 65535, 12345);
		send_fields(MODE_FIELD, 2048, 1024, 0, 49152, 65535);
		// turret-relative heading wraps below zero
		send_fields(MODE_TURRET, 2048, 1024, 0, 0, 16384);
		send_fields(MODE_TURRET, 4096, 0, 0, 100, 65535);
		send_fields(MODE_TURRET, 4096, 4096, 4096, 65535, 0);
		send_fields(MODE_TURRET, -4096, 3000, -8000, 32768, 32768);
		send_fields(MODE_TURRET, 32767, -32768, 0, 8191, 8192);
		// pure rotation at both extremes
		send_fields(MODE_FIELD, 0, 0, 32767, 0, 0);
		send_fields(MODE_FIELD, 0, 0, -32768, 0, 0);
		// tiny values exercise rounding
		send_fields(MODE_FIELD, 3, -3, 1, 16383, 0);
		send_fields(MODE_FIELD, -1, 1, -1, 16385, 0);
		send_fields(MODE_FIELD, 1500, 1500, 0, 32767, 0);
		send_fields(MODE_FIELD, 1500, -1500, 0, 32769, 0);
		send_fields(MODE_TURRET, -2500, 700, 300, 49151, 65535);
		send_fields(MODE_TURRET, 12000, -12000, 2000, 1, 2);
		wait_for_wheels();
	endtask

	task automatic test_register_extremes();
		// zero limit: every wheel forced to zero, flagged when nonzero
		write_register(fodk_pkg::CFG_CENTER_DISTANCE, 20'h00000);
		write_register(fodk_pkg::CFG_RPM_GAIN, 20'hFFFFF);
		write_register(fodk_pkg::CFG_MAX_RPM, 20'h00000);
		send_fields(MODE_FIELD, 0, 0, 0, 0, 0);
		send_fields(MODE_FIELD, 1, 0, 32767, 0, 0);
		for (int n = 0; n < 8; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		// full-scale limit and distance
		write_register(fodk_pkg::CFG_MAX_RPM, 20'hFFFFF);
		write_register(fodk_pkg::CFG_CENTER_DISTANCE, 20'hFFFFF);
		send_fields(MODE_FIELD, 32767, -32768, 32767, 0, 0);
		send_fields(MODE_TURRET, -32768, 32767, -32768, 12345, 54321);
		for (int n = 0; n < 8; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		// zero gain gives zero rpm everywhere
		write_register(fodk_pkg::CFG_RPM_GAIN, 20'h00000);
		for (int n = 0; n < 6; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		// unused index must leave all registers alone
		write_register(fodk_pkg::CFG_RPM_GAIN, 20'h12345);
		write_register(fodk_pkg::CFG_MAX_RPM, 20'hFA5A5);
		write_register(fodk_pkg::cfg_index_t'(CFG_UNUSED_INDEX), 20'hFFFFF);
		for (int n = 0; n < 8; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		write_register(fodk_pkg::CFG_CENTER_DISTANCE, 20'(fodk_pkg::RST_CENTER_DISTANCE));
		write_register(fodk_pkg::CFG_RPM_GAIN, fodk_pkg::RST_RPM_GAIN);
		write_register(fodk_pkg::CFG_MAX_RPM, 20'(fodk_pkg::RST_MAX_RPM));
	endtask

	// Hold off the receiver while commands keep coming, so the input stalls
	task automatic test_input_backpressure();
		send_gaps_en = 1'b0;
		hold_requests++;
		for (int n = 0; n < 48; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		send_gaps_en = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_register(fodk_pkg::CFG_CENTER_DISTANCE,
				rand_reg(16, 20'(fodk_pkg::RST_CENTER_DISTANCE)));
			write_register(fodk_pkg::CFG_RPM_GAIN, rand_reg(20, fodk_pkg::RST_RPM_GAIN));
			write_register(fodk_pkg::CFG_MAX_RPM,
				rand_reg(15, 20'(fodk_pkg::RST_MAX_RPM)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_cmd(rand_cmd());
				// pause the sender now and then until the block runs dry
				if ($urandom_range(199) == 0)
					wait_for_wheels();
			end
			wait_for_wheels();
		end
	endtask

	// Back-to-back commands with the receiver always ready
	task automatic test_steady_stream();
		send_gaps_en = 1'b0;
		recv_idle_en = 1'b0;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_cmd(rand_cmd());
		wait_for_wheels();
		send_gaps_en = 1'b1;
		recv_idle_en = 1'b1;
	endtask

	initial begin
		build_sine_table();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_extremes();
		test_input_backpressure();
		test_random_traffic();
		test_steady_stream();
		wait_for_wheels();
		$display("Sent %0d commands in both heading modes, checked %0d wheel items",
			cmds_sent, wheels_checked);
		$display("Made %0d register writes: zero and full-scale values, unused index",
			cfg_writes);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
